// File: sv/ibpt_pkg.sv
// Shared constants, types and the arctangent table of the inverse body pose transform.
package ibpt_pkg;

   // Default sizes of the coordinate and angle fields.
   localparam int COORD_WIDTH_DEF = 24;
   localparam int ANGLE_WIDTH_DEF = 16;

   // CORDIC datapath: 32-bit turn fractions, cosine and sine in Q1.30.
   localparam int CORDIC_WIDTH  = 32;
   localparam int CORDIC_STEPS  = 20;
   localparam int CS_FRAC_BITS  = 30;
   localparam int ANGLE_LANES   = 3;
   localparam logic [CORDIC_WIDTH-1:0] CORDIC_GAIN = 32'd652032874;

   // Lane order inside the CORDIC chain.
   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_YAW   = 2;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 3;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_POSE_X      = 3'd0,
      CSR_POSE_Y      = 3'd1,
      CSR_POSE_Z      = 3'd2,
      CSR_ROLL_ANGLE  = 3'd3,
      CSR_PITCH_ANGLE = 3'd4,
      CSR_YAW_ANGLE   = 3'd5
   } csr_reg_type;

   // State of the three angle lanes as it moves from cell to cell.
   typedef struct packed {
      logic [ANGLE_LANES-1:0]                   flip;
      logic [ANGLE_LANES-1:0][CORDIC_WIDTH-1:0] x;
      logic [ANGLE_LANES-1:0][CORDIC_WIDTH-1:0] y;
      logic [ANGLE_LANES-1:0][CORDIC_WIDTH-1:0] z;
   } cordic_type;

   // Arctangent of 2^-step in units of 2^-32 turn.
   function automatic logic [CORDIC_WIDTH-1:0] atan_turn(input int step);
      logic [CORDIC_WIDTH-1:0] value;
      case (step)
         0:  value = 32'd536870912;
         1:  value = 32'd316933406;
         2:  value = 32'd167458907;
         3:  value = 32'd85004756;
         4:  value = 32'd42667331;
         5:  value = 32'd21354465;
         6:  value = 32'd10679838;
         7:  value = 32'd5340245;
         8:  value = 32'd2670163;
         9:  value = 32'd1335087;
         10: value = 32'd667544;
         11: value = 32'd333772;
         12: value = 32'd166886;
         13: value = 32'd83443;
         14: value = 32'd41722;
         15: value = 32'd20861;
         16: value = 32'd10430;
         17: value = 32'd5215;
         18: value = 32'd2608;
         19: value = 32'd1304;
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

// File: sv/ibpt_cordic_cell.sv
// One CORDIC rotation step for the three pose angles, passing the point offset along.
module ibpt_cordic_cell
   import ibpt_pkg::*;
#(
   parameter int STEP        = 0,
   parameter int POINT_WIDTH = 3 * (COORD_WIDTH_DEF + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  cordic_type             in_cs,
   input  logic [POINT_WIDTH-1:0] in_point,
   output logic                   out_valid,
   output cordic_type             out_cs,
   output logic [POINT_WIDTH-1:0] out_point
);

   localparam logic signed [CORDIC_WIDTH-1:0] ATAN = atan_turn(STEP);

   logic                   valid_ff;
   cordic_type             cs_ff;
   cordic_type             cs_in;
   logic [POINT_WIDTH-1:0] point_ff;

   // Rotate each lane toward zero residue; the lanes are independent.
   always_comb begin
      logic signed [CORDIC_WIDTH-1:0] xs;
      logic signed [CORDIC_WIDTH-1:0] ys;
      logic signed [CORDIC_WIDTH-1:0] zs;
      cs_in      = in_cs;
      for (int k = 0; k < ANGLE_LANES; k++) begin
         xs = $signed(in_cs.x[k]);
         ys = $signed(in_cs.y[k]);
         zs = $signed(in_cs.z[k]);
         if (!zs[CORDIC_WIDTH-1]) begin
            cs_in.x[k] = xs - (ys >>> STEP);
            cs_in.y[k] = ys + (xs >>> STEP);
            cs_in.z[k] = zs - ATAN;
         end else begin
            cs_in.x[k] = xs + (ys >>> STEP);
            cs_in.y[k] = ys - (xs >>> STEP);
            cs_in.z[k] = zs + ATAN;
         end
      end
   end

   // The valid bit is control state; the payload needs no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      cs_ff    <= cs_in;
      point_ff <= in_point;
   end

   assign out_valid = valid_ff;
   assign out_cs    = cs_ff;
   assign out_point = point_ff;

endmodule

// File: sv/ibpt_rotate_stage.sv
// Two-stage planar rotation: a = c*u + s*v and b = c*v - s*u, rounded from Q1.30.
module ibpt_rotate_stage
   import ibpt_pkg::*;
#(
   parameter int VALUE_WIDTH = COORD_WIDTH_DEF + 3,
   parameter int SIDE_WIDTH  = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [CORDIC_WIDTH-1:0] in_c,
   input  logic signed [CORDIC_WIDTH-1:0] in_s,
   input  logic signed [VALUE_WIDTH-1:0]  in_u,
   input  logic signed [VALUE_WIDTH-1:0]  in_v,
   input  logic [SIDE_WIDTH-1:0]          in_side,
   output logic                           out_valid,
   output logic signed [VALUE_WIDTH-1:0]  out_a,
   output logic signed [VALUE_WIDTH-1:0]  out_b,
   output logic [SIDE_WIDTH-1:0]          out_side
);

   localparam int PROD_WIDTH = CORDIC_WIDTH + VALUE_WIDTH;
   localparam int SUM_WIDTH  = PROD_WIDTH + 1;
   localparam logic [SUM_WIDTH-1:0] ROUND = SUM_WIDTH'(1) << (CS_FRAC_BITS - 1);

   logic                         mul_valid_ff;
   logic signed [PROD_WIDTH-1:0] p_cu_ff;
   logic signed [PROD_WIDTH-1:0] p_sv_ff;
   logic signed [PROD_WIDTH-1:0] p_cv_ff;
   logic signed [PROD_WIDTH-1:0] p_su_ff;
   logic [SIDE_WIDTH-1:0]        mul_side_ff;

   logic                         add_valid_ff;
   logic [SUM_WIDTH-1:0]         sum_a_in;
   logic [SUM_WIDTH-1:0]         sum_b_in;
   logic signed [VALUE_WIDTH-1:0] a_ff;
   logic signed [VALUE_WIDTH-1:0] b_ff;
   logic [SIDE_WIDTH-1:0]        add_side_ff;

   // First stage: the four products.
   always_ff @(posedge clock) begin
      p_cu_ff     <= PROD_WIDTH'(in_c * in_u);
      p_sv_ff     <= PROD_WIDTH'(in_s * in_v);
      p_cv_ff     <= PROD_WIDTH'(in_c * in_v);
      p_su_ff     <= PROD_WIDTH'(in_s * in_u);
      mul_side_ff <= in_side;
   end

   // Second stage: sums with round half up, then the shift down by the fraction bits.
   assign sum_a_in = {p_cu_ff[PROD_WIDTH-1], p_cu_ff}
                   + {p_sv_ff[PROD_WIDTH-1], p_sv_ff} + ROUND;
   assign sum_b_in = {p_cv_ff[PROD_WIDTH-1], p_cv_ff}
                   - {p_su_ff[PROD_WIDTH-1], p_su_ff} + ROUND;

   always_ff @(posedge clock) begin
      a_ff        <= sum_a_in[CS_FRAC_BITS +: VALUE_WIDTH];
      b_ff        <= sum_b_in[CS_FRAC_BITS +: VALUE_WIDTH];
      add_side_ff <= mul_side_ff;
   end

   // Valid bits follow the two stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         add_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= in_valid;
         add_valid_ff <= mul_valid_ff;
      end
   end

   assign out_valid = add_valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_side  = add_side_ff;

endmodule

// File: sv/inverse_body_pose_transform.sv
// Top level of the inverse body pose transform: pose registers, CORDIC chain and rotations.
//
//   channel   ports                                   transfer
//   request   start, busy, req_point_x/y/z            start high while busy low
//   response  rsp_valid, rsp_out_x/y/z, rsp_saturated one-cycle strobe on rsp_valid
//   config    csr_valid, csr_ready, csr_index, csr_data  valid and ready high
//
// A new point is taken in every cycle; busy stays low. Each point passes through
// one entry stage, a chain of 20 CORDIC cells that turn the three pose angles into cosine
// and sine, one sign-fix stage, three rotations of two stages each (multiply, then add and
// round) and one saturation stage. Reset is synchronous and clears the pose registers and
// the valid bits. The receiver cannot stall the response.
module inverse_body_pose_transform
   import ibpt_pkg::*;
#(
   parameter int COORD_WIDTH = COORD_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic signed [COORD_WIDTH-1:0]       req_point_x,
   input  logic signed [COORD_WIDTH-1:0]       req_point_y,
   input  logic signed [COORD_WIDTH-1:0]       req_point_z,
   output logic                                rsp_valid,
   output logic signed [COORD_WIDTH-1:0]       rsp_out_x,
   output logic signed [COORD_WIDTH-1:0]       rsp_out_y,
   output logic signed [COORD_WIDTH-1:0]       rsp_out_z,
   output logic                                rsp_saturated,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0]          csr_index,
   input  logic [(COORD_WIDTH > ANGLE_WIDTH ? COORD_WIDTH : ANGLE_WIDTH)-1:0] csr_data
);

   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int POINT_WIDTH = 3 * DIFF_WIDTH;
   localparam int VALUE_WIDTH = COORD_WIDTH + 3;
   localparam int PAD_WIDTH   = CORDIC_WIDTH - ANGLE_WIDTH;

   // Pose registers.
   logic signed [COORD_WIDTH-1:0] pose_x_ff;
   logic signed [COORD_WIDTH-1:0] pose_y_ff;
   logic signed [COORD_WIDTH-1:0] pose_z_ff;
   logic [ANGLE_WIDTH-1:0]        roll_ff;
   logic [ANGLE_WIDTH-1:0]        pitch_ff;
   logic [ANGLE_WIDTH-1:0]        yaw_ff;

   // Entry stage.
   logic                   entry_valid_ff;
   cordic_type             entry_cs_in;
   cordic_type             entry_cs_ff;
   logic [POINT_WIDTH-1:0] entry_point_in;
   logic [POINT_WIDTH-1:0] entry_point_ff;
   logic [ANGLE_LANES-1:0][ANGLE_WIDTH-1:0] angle;

   // CORDIC chain.
   logic                   chain_valid [CORDIC_STEPS+1];
   cordic_type             chain_cs    [CORDIC_STEPS+1];
   logic [POINT_WIDTH-1:0] chain_point [CORDIC_STEPS+1];

   // Sign-fix stage.
   logic                           fix_valid_ff;
   logic signed [CORDIC_WIDTH-1:0] cr_ff;
   logic signed [CORDIC_WIDTH-1:0] sr_ff;
   logic signed [CORDIC_WIDTH-1:0] cp_ff;
   logic signed [CORDIC_WIDTH-1:0] nsp_ff;
   logic signed [CORDIC_WIDTH-1:0] cy_ff;
   logic signed [CORDIC_WIDTH-1:0] sy_ff;
   logic signed [VALUE_WIDTH-1:0]  dx_ff;
   logic signed [VALUE_WIDTH-1:0]  dy_ff;
   logic signed [VALUE_WIDTH-1:0]  dz_ff;
   logic [CORDIC_WIDTH-1:0]        cs_x [ANGLE_LANES];
   logic [CORDIC_WIDTH-1:0]        cs_y [ANGLE_LANES];
   logic [DIFF_WIDTH-1:0]          fin_dx;
   logic [DIFF_WIDTH-1:0]          fin_dy;
   logic [DIFF_WIDTH-1:0]          fin_dz;

   // Rotation stages.
   localparam int SIDE1_WIDTH = 4 * CORDIC_WIDTH + VALUE_WIDTH;
   localparam int SIDE2_WIDTH = 2 * CORDIC_WIDTH + VALUE_WIDTH;
   logic                           r1_valid;
   logic signed [VALUE_WIDTH-1:0]  x1;
   logic signed [VALUE_WIDTH-1:0]  y1;
   logic [SIDE1_WIDTH-1:0]         r1_side;
   logic signed [CORDIC_WIDTH-1:0] r1_cr;
   logic signed [CORDIC_WIDTH-1:0] r1_sr;
   logic signed [CORDIC_WIDTH-1:0] r1_cp;
   logic signed [CORDIC_WIDTH-1:0] r1_nsp;
   logic signed [VALUE_WIDTH-1:0]  r1_dz;
   logic                           r2_valid;
   logic signed [VALUE_WIDTH-1:0]  x2;
   logic signed [VALUE_WIDTH-1:0]  z2;
   logic [SIDE2_WIDTH-1:0]         r2_side;
   logic signed [CORDIC_WIDTH-1:0] r2_cr;
   logic signed [CORDIC_WIDTH-1:0] r2_sr;
   logic signed [VALUE_WIDTH-1:0]  r2_y1;
   logic                           r3_valid;
   logic signed [VALUE_WIDTH-1:0]  y3;
   logic signed [VALUE_WIDTH-1:0]  z3;
   logic [VALUE_WIDTH-1:0]         r3_x2;

   // Output stage.
   logic                          out_valid_ff;
   logic signed [COORD_WIDTH-1:0] out_x_ff;
   logic signed [COORD_WIDTH-1:0] out_y_ff;
   logic signed [COORD_WIDTH-1:0] out_z_ff;
   logic                          out_sat_ff;
   logic [COORD_WIDTH-1:0]        clip_x;
   logic [COORD_WIDTH-1:0]        clip_y;
   logic [COORD_WIDTH-1:0]        clip_z;
   logic                          sat_x;
   logic                          sat_y;
   logic                          sat_z;

   // Saturate a rotated value to the coordinate range.
   function automatic logic [COORD_WIDTH:0] clip_value(input logic [VALUE_WIDTH-1:0] v);
      logic                   sign;
      logic                   over;
      logic [COORD_WIDTH-1:0] bound;
      sign  = v[VALUE_WIDTH-1];
      over  = (v[VALUE_WIDTH-1:COORD_WIDTH-1] != {(VALUE_WIDTH-COORD_WIDTH+1){sign}});
      bound = {sign, {(COORD_WIDTH-1){~sign}}};
      return over ? {1'b1, bound} : {1'b0, v[COORD_WIDTH-1:0]};
   endfunction

   // The pipeline never holds off requests, and configuration writes are always taken.
   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration writes; indexes past the last register are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff <= '0;
         pose_y_ff <= '0;
         pose_z_ff <= '0;
         roll_ff   <= '0;
         pitch_ff  <= '0;
         yaw_ff    <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_POSE_X:      pose_x_ff <= csr_data[COORD_WIDTH-1:0];
            CSR_POSE_Y:      pose_y_ff <= csr_data[COORD_WIDTH-1:0];
            CSR_POSE_Z:      pose_z_ff <= csr_data[COORD_WIDTH-1:0];
            CSR_ROLL_ANGLE:  roll_ff   <= csr_data[ANGLE_WIDTH-1:0];
            CSR_PITCH_ANGLE: pitch_ff  <= csr_data[ANGLE_WIDTH-1:0];
            CSR_YAW_ANGLE:   yaw_ff    <= csr_data[ANGLE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Entry: exact offsets from the pose, and each angle folded into the right half plane.
   assign angle[LANE_ROLL]  = roll_ff;
   assign angle[LANE_PITCH] = pitch_ff;
   assign angle[LANE_YAW]   = yaw_ff;

   always_comb begin
      logic [CORDIC_WIDTH-1:0] turn;
      entry_cs_in = '0;
      for (int k = 0; k < ANGLE_LANES; k++) begin
         turn                = {angle[k], {PAD_WIDTH{1'b0}}};
         entry_cs_in.flip[k] = turn[CORDIC_WIDTH-1] ^ turn[CORDIC_WIDTH-2];
         if (entry_cs_in.flip[k]) begin
            turn[CORDIC_WIDTH-1] = ~turn[CORDIC_WIDTH-1];
         end
         entry_cs_in.x[k] = CORDIC_GAIN;
         entry_cs_in.y[k] = '0;
         entry_cs_in.z[k] = turn;
      end
      entry_point_in = {
         DIFF_WIDTH'({req_point_z[COORD_WIDTH-1], req_point_z}
                     - {pose_z_ff[COORD_WIDTH-1], pose_z_ff}),
         DIFF_WIDTH'({req_point_y[COORD_WIDTH-1], req_point_y}
                     - {pose_y_ff[COORD_WIDTH-1], pose_y_ff}),
         DIFF_WIDTH'({req_point_x[COORD_WIDTH-1], req_point_x}
                     - {pose_x_ff[COORD_WIDTH-1], pose_x_ff})
      };
   end

   always_ff @(posedge clock) begin
      entry_cs_ff    <= entry_cs_in;
      entry_point_ff <= entry_point_in;
   end

   // Row of CORDIC cells, one step per cell.
   assign chain_valid[0] = entry_valid_ff;
   assign chain_cs[0]    = entry_cs_ff;
   assign chain_point[0] = entry_point_ff;

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      ibpt_cordic_cell #(
         .STEP        (i),
         .POINT_WIDTH (POINT_WIDTH)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[i]),
         .in_cs     (chain_cs[i]),
         .in_point  (chain_point[i]),
         .out_valid (chain_valid[i+1]),
         .out_cs    (chain_cs[i+1]),
         .out_point (chain_point[i+1])
      );
   end

   // Sign fix: a folded angle negates both cosine and sine.
   always_comb begin
      for (int k = 0; k < ANGLE_LANES; k++) begin
         if (chain_cs[CORDIC_STEPS].flip[k]) begin
            cs_x[k] = -chain_cs[CORDIC_STEPS].x[k];
            cs_y[k] = -chain_cs[CORDIC_STEPS].y[k];
         end else begin
            cs_x[k] = chain_cs[CORDIC_STEPS].x[k];
            cs_y[k] = chain_cs[CORDIC_STEPS].y[k];
         end
      end
   end

   assign fin_dx = chain_point[CORDIC_STEPS][0 +: DIFF_WIDTH];
   assign fin_dy = chain_point[CORDIC_STEPS][DIFF_WIDTH +: DIFF_WIDTH];
   assign fin_dz = chain_point[CORDIC_STEPS][2*DIFF_WIDTH +: DIFF_WIDTH];

   always_ff @(posedge clock) begin
      cr_ff  <= cs_x[LANE_ROLL];
      sr_ff  <= cs_y[LANE_ROLL];
      cp_ff  <= cs_x[LANE_PITCH];
      nsp_ff <= -cs_y[LANE_PITCH];
      cy_ff  <= cs_x[LANE_YAW];
      sy_ff  <= cs_y[LANE_YAW];
      dx_ff  <= VALUE_WIDTH'($signed(fin_dx));
      dy_ff  <= VALUE_WIDTH'($signed(fin_dy));
      dz_ff  <= VALUE_WIDTH'($signed(fin_dz));
   end

   // Rotation by minus yaw about z.
   ibpt_rotate_stage #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .SIDE_WIDTH  (SIDE1_WIDTH)
   ) u_rot_yaw (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fix_valid_ff),
      .in_c      (cy_ff),
      .in_s      (sy_ff),
      .in_u      (dx_ff),
      .in_v      (dy_ff),
      .in_side   ({cr_ff, sr_ff, cp_ff, nsp_ff, dz_ff}),
      .out_valid (r1_valid),
      .out_a     (x1),
      .out_b     (y1),
      .out_side  (r1_side)
   );

   assign {r1_cr, r1_sr, r1_cp, r1_nsp, r1_dz} = r1_side;

   // Rotation by minus pitch about y.
   ibpt_rotate_stage #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .SIDE_WIDTH  (SIDE2_WIDTH)
   ) u_rot_pitch (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r1_valid),
      .in_c      (r1_cp),
      .in_s      (r1_nsp),
      .in_u      (x1),
      .in_v      (r1_dz),
      .in_side   ({r1_cr, r1_sr, y1}),
      .out_valid (r2_valid),
      .out_a     (x2),
      .out_b     (z2),
      .out_side  (r2_side)
   );

   assign {r2_cr, r2_sr, r2_y1} = r2_side;

   // Rotation by minus roll about x.
   ibpt_rotate_stage #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .SIDE_WIDTH  (VALUE_WIDTH)
   ) u_rot_roll (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (r2_valid),
      .in_c      (r2_cr),
      .in_s      (r2_sr),
      .in_u      (r2_y1),
      .in_v      (z2),
      .in_side   (x2),
      .out_valid (r3_valid),
      .out_a     (y3),
      .out_b     (z3),
      .out_side  (r3_x2)
   );

   // Saturation and the response registers.
   assign {sat_x, clip_x} = clip_value(r3_x2);
   assign {sat_y, clip_y} = clip_value(y3);
   assign {sat_z, clip_z} = clip_value(z3);

   always_ff @(posedge clock) begin
      out_x_ff   <= clip_x;
      out_y_ff   <= clip_y;
      out_z_ff   <= clip_z;
      out_sat_ff <= sat_x | sat_y | sat_z;
   end

   // Valid bits of the stages owned by the top level.
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
         fix_valid_ff   <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         entry_valid_ff <= start && !busy;
         fix_valid_ff   <= chain_valid[CORDIC_STEPS];
         out_valid_ff   <= r3_valid;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_x     = out_x_ff;
   assign rsp_out_y     = out_y_ff;
   assign rsp_out_z     = out_z_ff;
   assign rsp_saturated = out_sat_ff;

endmodule
